### hw/rtl/rti_pkg.sv
// Package for the ray/triangle intersection unit.
// Holds configuration register indexes and fixed output widths; no dependencies.
package rti_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int DIST_BITS = 31;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORG_X = 3'd0,
    CFG_ORG_Y = 3'd1,
    CFG_ORG_Z = 3'd2,
    CFG_DIR_X = 3'd3,
    CFG_DIR_Y = 3'd4,
    CFG_DIR_Z = 3'd5
  } cfg_idx_t;

endpackage

### hw/rtl/rti_if.sv
// Valid/ready channel interfaces for triangle words and result words.
// Depends on rti_pkg for the distance width.
interface rti_tri_if #(parameter int COORD_WIDTH = 32);
  logic valid;
  logic ready;
  logic signed [COORD_WIDTH-1:0] v0_x, v0_y, v0_z;
  logic signed [COORD_WIDTH-1:0] v1_x, v1_y, v1_z;
  logic signed [COORD_WIDTH-1:0] v2_x, v2_y, v2_z;

  modport source (output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                  input ready);
  modport sink (input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                output ready);
endinterface

interface rti_res_if;
  logic valid;
  logic ready;
  logic hit;
  logic [rti_pkg::DIST_BITS-1:0] hit_distance;

  modport source (output valid, hit, hit_distance, input ready);
  modport sink (input valid, hit, hit_distance, output ready);
endinterface

### hw/rtl/rti_mul.sv
// Two-stage signed multiplier built from four half-width partial products.
// Standalone; advances only when en is high.
module rti_mul #(
  parameter int WA = 33,
  parameter int WB = 33
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [WA-1:0]    a,
  input  logic signed [WB-1:0]    b,
  output logic signed [WA+WB-1:0] p
);

  localparam int KA = (WA + 1) / 2;
  localparam int KB = (WB + 1) / 2;
  localparam int HA = WA - KA;
  localparam int HB = WB - KB;
  localparam int PW = WA + WB;

  logic signed [HA-1:0]      ah;
  logic signed [KA:0]        al;
  logic signed [HB-1:0]      bh;
  logic signed [KB:0]        bl;
  logic signed [HA+HB-1:0]   hh_r;
  logic signed [HA+KB:0]     hl_r;
  logic signed [KA+HB:0]     lh_r;
  logic signed [KA+KB+1:0]   ll_r;
  logic signed [PW-1:0]      p_r;

  assign ah = a[WA-1:KA];
  assign al = {1'b0, a[KA-1:0]};
  assign bh = b[WB-1:KB];
  assign bl = {1'b0, b[KB-1:0]};

  always_ff @(posedge clk) begin
    if (en) begin
      hh_r <= ah * bh;
      hl_r <= ah * bl;
      lh_r <= al * bh;
      ll_r <= al * bl;
      p_r  <= (PW'(hh_r) <<< (KA + KB)) + (PW'(hl_r) <<< KA) + (PW'(lh_r) <<< KB)
              + PW'(ll_r);
    end
  end

  assign p = p_r;

endmodule

### hw/rtl/rti_div.sv
// Pipelined restoring divider: floor(num * 2^FRAC / den), one quotient bit per stage.
// Saturates at all ones; standalone, advances only when en is high.
module rti_div #(
  parameter int SW   = 102,
  parameter int FRAC = 16,
  parameter int QB   = 31
) (
  input  logic          clk,
  input  logic          en,
  input  logic          hit,
  input  logic [SW-1:0] num,
  input  logic [SW-1:0] den,
  output logic          hit_out,
  output logic [QB-1:0] dist_q
);

  localparam int RW = ((FRAC > QB) ? FRAC : QB) + SW + 1;

  logic [RW-1:0] rem_r [0:QB];
  logic [QB-1:0] q_r   [0:QB];
  logic [SW-1:0] d_r   [0:QB];
  logic          sat_r [0:QB];
  logic          hit_r [0:QB];
  logic [RW-1:0] rem0;

  assign rem0 = RW'(num) << FRAC;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= rem0;
      q_r[0]   <= '0;
      d_r[0]   <= den;
      sat_r[0] <= rem0 >= (RW'(den) << QB);
      hit_r[0] <= hit;
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_stage
    localparam int I = QB - k;
    logic [RW-1:0] sh;
    logic          ge;
    assign sh = RW'(d_r[k-1]) << I;
    assign ge = rem_r[k-1] >= sh;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? rem_r[k-1] - sh : rem_r[k-1];
        q_r[k]   <= q_r[k-1] | (QB'(ge) << I);
        d_r[k]   <= d_r[k-1];
        sat_r[k] <= sat_r[k-1];
        hit_r[k] <= hit_r[k-1];
      end
    end
  end

  assign hit_out = hit_r[QB];
  assign dist_q  = !hit_r[QB] ? '0 : (sat_r[QB] ? '1 : q_r[QB]);

endmodule

### hw/rtl/ray_triangle_intersect_unit.sv
// Ray/triangle intersection unit (Moller-Trumbore, exact fixed point).
// Throughput is one triangle per cycle; the whole pipeline holds when the
// output register is full and not taken. Depth is set by the 31-step divider.
// Synchronous active-low reset clears valid bits and the ray registers to zero.
module ray_triangle_intersect_unit #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  rti_tri_if.sink                         in_ch,
  rti_res_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [rti_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [COORD_WIDTH-1:0]          cfg_data
);

  import rti_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int EW  = W + 1;
  localparam int PW  = 2 * W + 2;
  localparam int QW  = 2 * W + 3;
  localparam int SW  = 3 * W + 6;
  localparam int LAT = 10 + DIST_BITS + 1;

  logic signed [W-1:0]  org_r [0:2];
  logic signed [W-1:0]  dir_r [0:2];
  logic                 vld_r [0:LAT-1];
  logic                 en;

  logic signed [W-1:0]  v0 [0:2];
  logic signed [W-1:0]  v1 [0:2];
  logic signed [W-1:0]  v2 [0:2];

  logic signed [EW-1:0] e1_r [0:3][0:2];
  logic signed [EW-1:0] e2_r [0:3][0:2];
  logic signed [EW-1:0] tv_r [0:3][0:2];

  logic signed [W+EW-1:0]  pa [0:2];
  logic signed [W+EW-1:0]  pb [0:2];
  logic signed [2*EW-1:0]  qa [0:2];
  logic signed [2*EW-1:0]  qb [0:2];
  logic signed [PW-1:0]    p_r [0:2];
  logic signed [QW-1:0]    q_r [0:2];

  logic signed [EW+PW-1:0] dm [0:2];
  logic signed [EW+PW-1:0] um [0:2];
  logic signed [W+QW-1:0]  vm [0:2];
  logic signed [EW+QW-1:0] tm [0:2];

  logic signed [SW-1:0] det_r, un_r, vn_r, tn_r;
  logic signed [SW-1:0] det_n_r, un_n_r, vn_n_r, tn_n_r;
  logic                 nz_r;
  logic signed [SW:0]   uv;
  logic                 hit_c_r;
  logic [SW-1:0]        tn_c_r, det_c_r;
  logic                 div_hit;
  logic [DIST_BITS-1:0] div_dist;
  logic                 hit_r;
  logic [DIST_BITS-1:0] dist_r;

  assign en          = !vld_r[LAT-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        org_r[i] <= '0;
        dir_r[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_ORG_X: org_r[0] <= cfg_data;
        CFG_ORG_Y: org_r[1] <= cfg_data;
        CFG_ORG_Z: org_r[2] <= cfg_data;
        CFG_DIR_X: dir_r[0] <= cfg_data;
        CFG_DIR_Y: dir_r[1] <= cfg_data;
        CFG_DIR_Z: dir_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_ch.valid;
      for (int i = 1; i < LAT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  assign v0[0] = in_ch.v0_x;
  assign v0[1] = in_ch.v0_y;
  assign v0[2] = in_ch.v0_z;
  assign v1[0] = in_ch.v1_x;
  assign v1[1] = in_ch.v1_y;
  assign v1[2] = in_ch.v1_z;
  assign v2[0] = in_ch.v2_x;
  assign v2[1] = in_ch.v2_y;
  assign v2[2] = in_ch.v2_z;

  // Edges and origin offset, then a delay line of registers that lines them up with P and Q.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e1_r[0][i] <= EW'(v1[i]) - EW'(v0[i]);
        e2_r[0][i] <= EW'(v2[i]) - EW'(v0[i]);
        tv_r[0][i] <= EW'(org_r[i]) - EW'(v0[i]);
      end
      for (int d = 1; d < 4; d++) begin
        e1_r[d] <= e1_r[d-1];
        e2_r[d] <= e2_r[d-1];
        tv_r[d] <= tv_r[d-1];
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_cross
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;
    rti_mul #(.WA(W), .WB(EW)) u_pa (
      .clk(clk), .en(en), .a(dir_r[J]), .b(e2_r[0][K]), .p(pa[i]));
    rti_mul #(.WA(W), .WB(EW)) u_pb (
      .clk(clk), .en(en), .a(dir_r[K]), .b(e2_r[0][J]), .p(pb[i]));
    rti_mul #(.WA(EW), .WB(EW)) u_qa (
      .clk(clk), .en(en), .a(tv_r[0][J]), .b(e1_r[0][K]), .p(qa[i]));
    rti_mul #(.WA(EW), .WB(EW)) u_qb (
      .clk(clk), .en(en), .a(tv_r[0][K]), .b(e1_r[0][J]), .p(qb[i]));

    always_ff @(posedge clk) begin
      if (en) begin
        p_r[i] <= PW'(pa[i]) - PW'(pb[i]);
        q_r[i] <= QW'(qa[i]) - QW'(qb[i]);
      end
    end

    rti_mul #(.WA(EW), .WB(PW)) u_dm (
      .clk(clk), .en(en), .a(e1_r[3][i]), .b(p_r[i]), .p(dm[i]));
    rti_mul #(.WA(EW), .WB(PW)) u_um (
      .clk(clk), .en(en), .a(tv_r[3][i]), .b(p_r[i]), .p(um[i]));
    rti_mul #(.WA(W), .WB(QW)) u_vm (
      .clk(clk), .en(en), .a(dir_r[i]), .b(q_r[i]), .p(vm[i]));
    rti_mul #(.WA(EW), .WB(QW)) u_tm (
      .clk(clk), .en(en), .a(e2_r[3][i]), .b(q_r[i]), .p(tm[i]));
  end

  assign uv = (SW+1)'(un_n_r) + (SW+1)'(vn_n_r);

  always_ff @(posedge clk) begin
    if (en) begin
      det_r <= SW'(dm[0]) + SW'(dm[1]) + SW'(dm[2]);
      un_r  <= SW'(um[0]) + SW'(um[1]) + SW'(um[2]);
      vn_r  <= SW'(vm[0]) + SW'(vm[1]) + SW'(vm[2]);
      tn_r  <= SW'(tm[0]) + SW'(tm[1]) + SW'(tm[2]);

      nz_r    <= det_r != '0;
      det_n_r <= det_r[SW-1] ? -det_r : det_r;
      un_n_r  <= det_r[SW-1] ? -un_r  : un_r;
      vn_n_r  <= det_r[SW-1] ? -vn_r  : vn_r;
      tn_n_r  <= det_r[SW-1] ? -tn_r  : tn_r;

      hit_c_r <= nz_r && !un_n_r[SW-1] && !(un_n_r > det_n_r) && !vn_n_r[SW-1]
                 && !(uv > (SW+1)'(det_n_r)) && (tn_n_r > 0);
      tn_c_r  <= tn_n_r;
      det_c_r <= det_n_r;
    end
  end

  rti_div #(.SW(SW), .FRAC(FRAC_BITS), .QB(DIST_BITS)) u_div (
    .clk(clk), .en(en), .hit(hit_c_r), .num(tn_c_r), .den(det_c_r),
    .hit_out(div_hit), .dist_q(div_dist));

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r  <= div_hit;
      dist_r <= div_dist;
    end
  end

  assign out_ch.valid        = vld_r[LAT-1];
  assign out_ch.hit          = hit_r;
  assign out_ch.hit_distance = dist_r;

endmodule

### hw/rtl/rti_chk.sv
// Port-level checker for the ray/triangle intersection unit.
// Depends on rti_pkg; bound to ray_triangle_intersect_unit below.
module rti_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_hit,
  input logic [rti_pkg::DIST_BITS-1:0] out_dist
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_dist == '0)
    else $error("miss with nonzero distance");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with free output");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid after reset");

endmodule

bind ray_triangle_intersect_unit rti_chk u_rti_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_hit(out_ch.hit), .out_dist(out_ch.hit_distance));
